FILE: hdl/bfknn_pkg.sv
package bfknn_pkg;

    localparam int MAX_K_DEF         = 16;
    localparam int ELEMENT_BITS_DEF  = 16;
    localparam int DISTANCE_BITS_DEF = 48;

    localparam int ID_BITS     = 64;
    localparam int TOP_K_BITS  = 5;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [TOP_K_BITS-1:0] TOP_K_RESET = 5'd16;

    typedef enum logic {
        CFG_METRIC = 1'b0,
        CFG_TOP_K  = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        METRIC_L2 = 1'b0,
        METRIC_IP = 1'b1
    } t_metric;

    typedef enum logic {
        ST_COLLECT,
        ST_EMIT
    } t_back_state;

    typedef struct packed {
        logic keep;
        logic scan_end;
    } t_cand_flags;

endpackage

FILE: hdl/bfknn_if.sv
interface bfknn_in_if #(
    parameter int ELEMENT_BITS = bfknn_pkg::ELEMENT_BITS_DEF
);
    logic                             valid;
    logic                             ready;
    logic [bfknn_pkg::ID_BITS-1:0]    node_id;
    logic signed [ELEMENT_BITS-1:0]   query_value;
    logic signed [ELEMENT_BITS-1:0]   node_value;
    logic                             last_element;
    logic                             excluded;
    logic                             last_node;

    modport source (
        output valid, node_id, query_value, node_value, last_element, excluded, last_node,
        input  ready
    );
    modport sink (
        input  valid, node_id, query_value, node_value, last_element, excluded, last_node,
        output ready
    );
endinterface

interface bfknn_out_if #(
    parameter int DISTANCE_BITS = bfknn_pkg::DISTANCE_BITS_DEF
);
    logic                             valid;
    logic                             ready;
    logic [bfknn_pkg::ID_BITS-1:0]    result_id;
    logic signed [DISTANCE_BITS-1:0]  result_distance;
    logic                             found;
    logic                             last;

    modport source (
        output valid, result_id, result_distance, found, last,
        input  ready
    );
    modport sink (
        input  valid, result_id, result_distance, found, last,
        output ready
    );
endinterface

interface bfknn_cfg_if;
    logic                                valid;
    logic                                ready;
    bfknn_pkg::t_cfg_reg                 index;
    logic [bfknn_pkg::TOP_K_BITS-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/bfknn_front.sv
module bfknn_front #(
    parameter int ELEMENT_BITS  = bfknn_pkg::ELEMENT_BITS_DEF,
    parameter int DISTANCE_BITS = bfknn_pkg::DISTANCE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bfknn_pkg::t_metric                 i_metric,
    bfknn_in_if.sink                           i_in,
    input  logic                               i_full,
    output logic                               o_push,
    output logic [bfknn_pkg::ID_BITS-1:0]      o_cand_id,
    output logic signed [DISTANCE_BITS-1:0]    o_cand_dist,
    output bfknn_pkg::t_cand_flags             o_cand_flags
);

    localparam int PW = 2 * ELEMENT_BITS + 2;
    localparam int CW = (PW > DISTANCE_BITS) ? PW : DISTANCE_BITS;
    localparam logic signed [CW-1:0] DMAX_W = CW'({1'b0, {(DISTANCE_BITS-1){1'b1}}});
    localparam logic signed [CW-1:0] DMIN_W = ~DMAX_W;

    logic                              en;
    logic                              accept;
    logic signed [ELEMENT_BITS:0]      q_x;
    logic signed [ELEMENT_BITS:0]      n_x;
    logic signed [ELEMENT_BITS:0]      diff;
    logic signed [PW-1:0]              prod;
    logic signed [CW-1:0]              p_w;
    logic signed [DISTANCE_BITS-1:0]   term_c;
    logic signed [DISTANCE_BITS:0]     sum_w;
    logic signed [DISTANCE_BITS-1:0]   acc_sum;

    logic                              r_v1;
    logic                              r_end1;
    bfknn_pkg::t_cand_flags            r_fl1;
    logic [bfknn_pkg::ID_BITS-1:0]     r_id1;
    logic signed [PW-1:0]              r_p1;

    logic                              r_v2;
    logic                              r_end2;
    bfknn_pkg::t_cand_flags            r_fl2;
    logic [bfknn_pkg::ID_BITS-1:0]     r_id2;
    logic signed [DISTANCE_BITS-1:0]   r_t2;

    logic signed [DISTANCE_BITS-1:0]   r_acc;

    // stage 1: one multiply per word
    assign q_x  = $signed({i_in.query_value[ELEMENT_BITS-1], i_in.query_value});
    assign n_x  = $signed({i_in.node_value[ELEMENT_BITS-1], i_in.node_value});
    assign diff = q_x - n_x;

    always_comb begin
        unique case (i_metric)
            bfknn_pkg::METRIC_L2: begin
                prod = diff * diff;
            end
            bfknn_pkg::METRIC_IP: begin
                prod = -(q_x * n_x);
            end
            default: begin
                prod = '0;
            end
        endcase
    end

    // stage 2: clamp term to distance range
    assign p_w    = CW'(r_p1);
    assign term_c = (p_w > DMAX_W) ? DMAX_W[DISTANCE_BITS-1:0] :
                    (p_w < DMIN_W) ? DMIN_W[DISTANCE_BITS-1:0] : p_w[DISTANCE_BITS-1:0];

    // stage 3: saturating accumulate
    assign sum_w   = {r_acc[DISTANCE_BITS-1], r_acc} + {r_t2[DISTANCE_BITS-1], r_t2};
    assign acc_sum = (sum_w[DISTANCE_BITS] != sum_w[DISTANCE_BITS-1]) ?
                     {sum_w[DISTANCE_BITS], {(DISTANCE_BITS-1){~sum_w[DISTANCE_BITS]}}} :
                     sum_w[DISTANCE_BITS-1:0];

    assign en         = !(r_v2 && r_end2 && i_full);
    assign i_in.ready = en;
    assign accept     = i_in.valid && en;

    assign o_push       = r_v2 && r_end2 && !i_full;
    assign o_cand_id    = r_id2;
    assign o_cand_dist  = acc_sum;
    assign o_cand_flags = r_fl2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_acc <= '0;
        end else if (en) begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            if (r_v2) begin
                r_acc <= r_end2 ? '0 : acc_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1           <= prod;
            r_id1          <= i_in.node_id;
            r_end1         <= i_in.last_element || i_in.last_node;
            r_fl1.keep     <= !i_in.excluded;
            r_fl1.scan_end <= i_in.last_node;
            r_t2           <= term_c;
            r_id2          <= r_id1;
            r_end2         <= r_end1;
            r_fl2          <= r_fl1;
        end
    end

endmodule

FILE: hdl/bfknn_queue.sv
module bfknn_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bfknn_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

FILE: hdl/bfknn_back.sv
module bfknn_back #(
    parameter int MAX_K         = bfknn_pkg::MAX_K_DEF,
    parameter int DISTANCE_BITS = bfknn_pkg::DISTANCE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [bfknn_pkg::TOP_K_BITS-1:0]      i_top_k,
    input  logic                                  i_empty,
    output logic                                  o_pop,
    input  logic [bfknn_pkg::ID_BITS-1:0]         i_cand_id,
    input  logic signed [DISTANCE_BITS-1:0]       i_cand_dist,
    input  bfknn_pkg::t_cand_flags                i_cand_flags,
    bfknn_out_if.source                           o_out
);

    localparam int CNT_W = $clog2(MAX_K + 1);
    localparam int IDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int KW    = (CNT_W > bfknn_pkg::TOP_K_BITS) ? CNT_W : bfknn_pkg::TOP_K_BITS;

    bfknn_pkg::t_back_state            r_state;
    bfknn_pkg::t_back_state            n_state;
    logic [CNT_W-1:0]                  r_cnt;
    logic [CNT_W-1:0]                  n_cnt;
    logic [IDX_W-1:0]                  r_idx;
    logic [IDX_W-1:0]                  n_idx;

    logic [bfknn_pkg::ID_BITS-1:0]     r_ids   [MAX_K];
    logic signed [DISTANCE_BITS-1:0]   r_dists [MAX_K];

    logic                              r_ov;
    logic [bfknn_pkg::ID_BITS-1:0]     r_oid;
    logic signed [DISTANCE_BITS-1:0]   r_odist;
    logic                              r_found;
    logic                              r_last;

    logic [MAX_K-1:0]                  gt;
    logic [MAX_K-1:0]                  sel;
    logic [KW-1:0]                     topk_w;
    logic [KW-1:0]                     keff;
    logic                              full;
    logic                              ins_en;
    logic                              load;
    logic                              out_free;
    logic                              emit_last;

    always_comb begin
        for (int i = 0; i < MAX_K; i++) begin
            gt[i]  = (CNT_W'(i) < r_cnt) && (r_dists[i] > i_cand_dist);
            sel[i] = (CNT_W'(i) >= r_cnt) || gt[i];
        end
    end

    assign topk_w = KW'(i_top_k);
    assign keff   = (topk_w == '0) ? KW'(1) :
                    (topk_w > KW'(MAX_K)) ? KW'(MAX_K) : topk_w;
    assign full   = KW'(r_cnt) >= keff;

    assign out_free  = !r_ov || o_out.ready;
    assign emit_last = (r_cnt == '0) || (CNT_W'(r_idx) + CNT_W'(1) == r_cnt);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        o_pop   = 1'b0;
        ins_en  = 1'b0;
        load    = 1'b0;
        unique case (r_state)
            bfknn_pkg::ST_COLLECT: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_cand_flags.keep && (!full || (|gt))) begin
                        ins_en = 1'b1;
                        n_cnt  = full ? r_cnt : r_cnt + 1'b1;
                    end
                    if (i_cand_flags.scan_end) begin
                        n_state = bfknn_pkg::ST_EMIT;
                        n_idx   = '0;
                    end
                end
            end
            bfknn_pkg::ST_EMIT: begin
                if (out_free) begin
                    load = 1'b1;
                    if (emit_last) begin
                        n_cnt   = '0;
                        n_state = bfknn_pkg::ST_COLLECT;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = bfknn_pkg::ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfknn_pkg::ST_COLLECT;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            if (load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // sorted insert: entries at and after the slot shift down by one
    always_ff @(posedge i_clk) begin
        if (ins_en) begin
            if (sel[0]) begin
                r_ids[0]   <= i_cand_id;
                r_dists[0] <= i_cand_dist;
            end
            for (int i = 1; i < MAX_K; i++) begin
                if (sel[i]) begin
                    if (!sel[i-1]) begin
                        r_ids[i]   <= i_cand_id;
                        r_dists[i] <= i_cand_dist;
                    end else begin
                        r_ids[i]   <= r_ids[i-1];
                        r_dists[i] <= r_dists[i-1];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_last <= emit_last;
            if (r_cnt == '0) begin
                r_oid   <= '0;
                r_odist <= '0;
                r_found <= 1'b0;
            end else begin
                r_oid   <= r_ids[r_idx];
                r_odist <= r_dists[r_idx];
                r_found <= 1'b1;
            end
        end
    end

    assign o_out.valid           = r_ov;
    assign o_out.result_id       = r_oid;
    assign o_out.result_distance = r_odist;
    assign o_out.found           = r_found;
    assign o_out.last            = r_last;

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_K))
        else $error("kept count beyond MAX_K");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && emit_last) |=> (r_cnt == '0 && r_state == bfknn_pkg::ST_COLLECT))
        else $error("list not cleared after final word");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_found) |-> r_last)
        else $error("empty result not marked last");

    a_list_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bfknn_pkg::ST_EMIT && n_state == bfknn_pkg::ST_EMIT) |=> $stable(r_cnt))
        else $error("kept count changed during emission");

endmodule

FILE: hdl/brute_force_knn_top_k_unit.sv
// channel  dir  handshake      word
// i_cfg    in   valid / ready  index (metric, top_k), data
// i_in     in   valid / ready  node_id, query_value, node_value, flags
// o_out    out  valid / ready  result_id, result_distance, found, last
//
// Front takes one element word per cycle unless a full candidate queue stalls it;
// a vector's distance reaches the queue through the stage 1 and stage 2 registers.
// While collecting, back inserts one candidate per cycle against all kept entries
// in parallel. Scan end: back emits max(kept, 1) words, one per cycle while
// o_out is ready; the 4-entry candidate queue then fills and stalls the front.
// Reset is synchronous; the kept list needs no clearing pass.
module brute_force_knn_top_k_unit #(
    parameter int MAX_K         = bfknn_pkg::MAX_K_DEF,
    parameter int ELEMENT_BITS  = bfknn_pkg::ELEMENT_BITS_DEF,
    parameter int DISTANCE_BITS = bfknn_pkg::DISTANCE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bfknn_cfg_if.sink   i_cfg,
    bfknn_in_if.sink    i_in,
    bfknn_out_if.source o_out
);

    localparam int QW = bfknn_pkg::ID_BITS + DISTANCE_BITS + $bits(bfknn_pkg::t_cand_flags);

    bfknn_pkg::t_metric                    r_metric;
    logic [bfknn_pkg::TOP_K_BITS-1:0]      r_top_k;

    logic                                  push;
    logic                                  pop;
    logic                                  full;
    logic                                  empty;
    logic [bfknn_pkg::ID_BITS-1:0]         cand_id;
    logic signed [DISTANCE_BITS-1:0]       cand_dist;
    bfknn_pkg::t_cand_flags                cand_flags;
    logic [QW-1:0]                         q_in;
    logic [QW-1:0]                         q_out;
    logic [bfknn_pkg::ID_BITS-1:0]         q_id;
    logic signed [DISTANCE_BITS-1:0]       q_dist;
    bfknn_pkg::t_cand_flags                q_flags;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metric <= bfknn_pkg::METRIC_L2;
            r_top_k  <= bfknn_pkg::TOP_K_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                bfknn_pkg::CFG_METRIC: r_metric <= bfknn_pkg::t_metric'(i_cfg.data[0]);
                bfknn_pkg::CFG_TOP_K:  r_top_k  <= i_cfg.data;
                default:               r_top_k  <= r_top_k;
            endcase
        end
    end

    bfknn_front #(
        .ELEMENT_BITS  (ELEMENT_BITS),
        .DISTANCE_BITS (DISTANCE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_metric     (r_metric),
        .i_in         (i_in),
        .i_full       (full),
        .o_push       (push),
        .o_cand_id    (cand_id),
        .o_cand_dist  (cand_dist),
        .o_cand_flags (cand_flags)
    );

    assign q_in = {cand_id, cand_dist, cand_flags};
    assign {q_id, q_dist, q_flags} = q_out;

    bfknn_queue #(
        .WIDTH (QW),
        .DEPTH (bfknn_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_empty (empty)
    );

    bfknn_back #(
        .MAX_K         (MAX_K),
        .DISTANCE_BITS (DISTANCE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_top_k      (r_top_k),
        .i_empty      (empty),
        .o_pop        (pop),
        .i_cand_id    (q_id),
        .i_cand_dist  (q_dist),
        .i_cand_flags (q_flags),
        .o_out        (o_out)
    );

endmodule
